// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers used by the rtl core
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked at every clock edge, disabled while reset is asserted
`define ASSERT_AR(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// property checked at every clock edge, also during reset
`define ASSERT_ALW(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_AR(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALW(lbl, clk, prop, msg)

`endif

`endif

// File: rtl/adcrb_pkg.sv
// ----------------------------------------------------------------------------
// adcrb_pkg
// opcodes, bus register map and status bit positions of the adc register block
// ----------------------------------------------------------------------------
package adcrb_pkg;

	// item opcodes
	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	// bus register map
	localparam logic [7:0] ADDR_SEL    = 8'd0;
	localparam logic [7:0] ADDR_START  = 8'd1;
	localparam logic [7:0] ADDR_STATUS = 8'd2;
	localparam logic [7:0] ADDR_RESULT = 8'd3;
	localparam logic [7:0] ADDR_RCHAN  = 8'd4;
	localparam logic [7:0] ADDR_IE     = 8'd5;

	// configuration register indexes
	localparam logic [1:0] CFG_CHAN_COUNT = 2'd0;
	localparam logic [1:0] CFG_RES_BITS   = 2'd1;
	localparam logic [1:0] CFG_VREF       = 2'd2;
	localparam logic [1:0] CFG_CONV_CYC   = 2'd3;

	// status bit positions
	localparam int ST_BUSY     = 0;
	localparam int ST_COMPLETE = 1;
	localparam int ST_OVERRUN  = 2;
	localparam int ST_INVALID  = 3;

	// configuration reset values
	localparam logic [4:0]  RST_CHAN_COUNT = 5'd1;
	localparam logic [4:0]  RST_RES_BITS   = 5'd12;
	localparam logic [14:0] RST_VREF       = 15'd3300;
	localparam logic [15:0] RST_CONV_CYC   = 16'd1;

	// number of quotient bits the divider produces
	localparam int DIV_STEPS = 16;

endpackage

// File: rtl/adc_conversion_register_block_core.sv
// ----------------------------------------------------------------------------
// adc_conversion_register_block_core
// register-mapped adc controller with a shared iterative code divider
// ----------------------------------------------------------------------------
// Each input transfer is a bus read, a bus write or a clock tick and gives one
// output transfer. Reads, writes and ticks that do not finish a conversion load
// their response into the output register when they are accepted. A tick that
// finishes a conversion runs the code computation round(v*maxcode/vref): a
// multiply step, a load step, a restoring divider that produces 16 quotient
// bits (one quotient bit per cycle) and a post of the result; during all of
// this s_tready is low, and the post waits while the output side holds off. A
// code that clamps to zero or full scale skips the load and divide steps. The
// input is taken whenever the sequencer is idle and the output register is
// empty or being emptied in the same cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module adc_conversion_register_block_core
	import adcrb_pkg::*;
#(
	parameter int MAX_CHANNELS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	// s_tdata: address[7:0], write_data[39:8], sample_millivolts[55:40],
	// sample_present[56], zero fill [63:57]
	input  logic [63:0] s_tdata,
	// s_tuser: opcode[1:0]
	input  logic [1:0]  s_tuser,
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// m_tdata: read_data[31:0], bad_address[32], irq_line[33], zero fill [39:34]
	output logic [39:0] m_tdata
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_LOAD,
		S_DIV,
		S_DONE
	} state_t;

	// input fields
	logic [1:0]         in_op;
	logic [7:0]         in_addr;
	logic [31:0]        in_wdata;
	logic [15:0]        in_sample;
	logic               in_present;

	// configuration
	logic [4:0]         cnt_q;
	logic [4:0]         res_q;
	logic [14:0]        vref_q;
	logic [15:0]        conv_q;

	// architectural state
	logic [31:0]        sel_q;
	logic [3:0]         act_q;
	logic [15:0]        held_q;
	logic [15:0]        cyc_q;
	logic [15:0]        code_q;
	logic [3:0]         rch_q;
	logic               busy_q;
	logic               cmpl_q;
	logic               ovr_q;
	logic               inv_q;
	logic               unread_q;
	logic               ie_q;

	// sequencer and divider datapath
	state_t             state_q;
	logic [3:0]         step_q;
	logic [30:0]        prod_q;
	logic [15:0]        den_q;
	logic [15:0]        rem_q;
	logic [15:0]        quo_q;

	// output register
	logic               m_tvalid_q;
	logic [33:0]        out_q;

	// derived values
	logic               accept;
	logic               out_free;
	logic               out_load;
	logic [4:0]         res_sat;
	logic [15:0]        maxcode;
	logic [14:0]        vref_eff;
	logic [31:0]        cnt_sat;
	logic [32:0]        num;
	logic [16:0]        trial;
	logic               qbit;

	// next values for an accepted item
	logic [31:0]        n_sel;
	logic [3:0]         n_act;
	logic [15:0]        n_held;
	logic [15:0]        n_cyc;
	logic               n_busy;
	logic               n_cmpl;
	logic               n_ovr;
	logic               n_inv;
	logic               n_unread;
	logic               n_ie;
	logic [31:0]        n_rd;
	logic               n_bad;
	logic               n_finish;
	logic [15:0]        cyc_dec;

	assign in_addr    = s_tdata[7:0];
	assign in_wdata   = s_tdata[39:8];
	assign in_sample  = s_tdata[55:40];
	assign in_present = s_tdata[56];
	assign in_op      = s_tuser;

	// handshake
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == S_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'd0, out_q};

	// output register loads the response to an item that does not finish a conversion, or a finished conversion
	assign out_load = (accept && !n_finish) || (state_q == S_DONE && out_free);

	// saturated configuration
	assign res_sat  = (res_q == 5'd0) ? 5'd1 : ((res_q > 5'd16) ? 5'd16 : res_q);
	assign maxcode  = 16'hFFFF >> (5'd16 - res_sat);
	assign vref_eff = (vref_q == 15'd0) ? 15'd1 : vref_q;
	assign cnt_sat  = ({27'd0, cnt_q} > 32'(MAX_CHANNELS)) ? 32'(MAX_CHANNELS)
		: {27'd0, cnt_q};

	// divider operands and one restoring step
	assign num   = {1'b0, prod_q, 1'b0} + {18'd0, vref_eff};
	assign trial = {rem_q, quo_q[15]};
	assign qbit  = trial >= {1'b0, den_q};

	// decode of an accepted item
	assign cyc_dec = (cyc_q != 16'd0) ? cyc_q - 16'd1 : 16'd0;

	always_comb begin
		n_sel    = sel_q;
		n_act    = act_q;
		n_held   = held_q;
		n_cyc    = cyc_q;
		n_busy   = busy_q;
		n_cmpl   = cmpl_q;
		n_ovr    = ovr_q;
		n_inv    = inv_q;
		n_unread = unread_q;
		n_ie     = ie_q;
		n_rd     = 32'd0;
		n_bad    = 1'b0;
		n_finish = 1'b0;
		unique case (in_op)
			OP_READ: begin
				unique case (in_addr)
					ADDR_SEL:    n_rd = sel_q;
					ADDR_START:  n_rd = 32'd0;
					ADDR_STATUS: n_rd = {28'd0, inv_q, ovr_q, cmpl_q, busy_q};
					ADDR_RESULT: begin
						n_rd     = {16'd0, code_q};
						n_unread = 1'b0;
					end
					ADDR_RCHAN:  n_rd = {28'd0, rch_q};
					ADDR_IE:     n_rd = {31'd0, ie_q};
					default:     n_bad = 1'b1;
				endcase
			end
			OP_WRITE: begin
				unique case (in_addr)
					ADDR_SEL:    n_sel = in_wdata;
					ADDR_START: begin
						if (in_wdata[0] && !busy_q) begin
							if (sel_q >= cnt_sat) begin
								n_inv = 1'b1;
							end else begin
								n_act  = sel_q[3:0];
								n_cyc  = conv_q;
								n_busy = 1'b1;
								if (in_present) begin
									n_held = in_sample;
								end
							end
						end
					end
					ADDR_STATUS: begin
						n_cmpl = cmpl_q && !in_wdata[ST_COMPLETE];
						n_ovr  = ovr_q && !in_wdata[ST_OVERRUN];
						n_inv  = inv_q && !in_wdata[ST_INVALID];
					end
					ADDR_RESULT, ADDR_RCHAN: begin
					end
					ADDR_IE:     n_ie = in_wdata != 32'd0;
					default:     n_bad = 1'b1;
				endcase
			end
			OP_TICK: begin
				if (busy_q) begin
					n_cyc = cyc_dec;
					if (cyc_dec == 16'd0) begin
						n_finish = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= RST_CHAN_COUNT;
			res_q  <= RST_RES_BITS;
			vref_q <= RST_VREF;
			conv_q <= RST_CONV_CYC;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CHAN_COUNT: cnt_q  <= cfg_data[4:0];
				CFG_RES_BITS:   res_q  <= cfg_data[4:0];
				CFG_VREF:       vref_q <= cfg_data[14:0];
				CFG_CONV_CYC:   conv_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// divider datapath, no reset needed
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_MUL: begin
				den_q  <= {vref_eff, 1'b0};
				prod_q <= 31'(held_q[14:0]) * 31'(maxcode);
				if (held_q[15] || held_q == 16'd0) begin
					quo_q <= 16'd0;
				end else if (held_q[14:0] >= vref_eff) begin
					quo_q <= maxcode;
				end
			end
			S_LOAD: begin
				rem_q <= num[31:16];
				quo_q <= num[15:0];
			end
			S_DIV: begin
				rem_q <= qbit ? 16'(trial - {1'b0, den_q}) : trial[15:0];
				quo_q <= {quo_q[14:0], qbit};
			end
			default: begin
			end
		endcase
	end

	// sequencer, architectural state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			step_q     <= 4'd0;
			sel_q      <= 32'd0;
			act_q      <= 4'd0;
			held_q     <= 16'd0;
			cyc_q      <= 16'd0;
			code_q     <= 16'd0;
			rch_q      <= 4'd0;
			busy_q     <= 1'b0;
			cmpl_q     <= 1'b0;
			ovr_q      <= 1'b0;
			inv_q      <= 1'b0;
			unread_q   <= 1'b0;
			ie_q       <= 1'b0;
			m_tvalid_q <= 1'b0;
			out_q      <= 34'd0;
		end else begin
			// output valid: set on a load, dropped once the transfer is taken
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						sel_q    <= n_sel;
						act_q    <= n_act;
						held_q   <= n_held;
						cyc_q    <= n_cyc;
						busy_q   <= n_busy;
						cmpl_q   <= n_cmpl;
						ovr_q    <= n_ovr;
						inv_q    <= n_inv;
						unread_q <= n_unread;
						ie_q     <= n_ie;
						if (n_finish) begin
							state_q <= S_MUL;
						end else begin
							out_q <= {n_cmpl && n_ie, n_bad, n_rd};
						end
					end
				end
				S_MUL: begin
					// clamped codes skip the divider
					if (held_q[15] || held_q == 16'd0 || held_q[14:0] >= vref_eff) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					step_q  <= 4'd0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'(DIV_STEPS - 1)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// post the finished conversion once the output slot is free
					if (out_free) begin
						code_q   <= quo_q;
						rch_q    <= act_q;
						ovr_q    <= ovr_q || unread_q;
						unread_q <= 1'b1;
						cmpl_q   <= 1'b1;
						busy_q   <= 1'b0;
						out_q    <= {ie_q, 1'b0, 32'd0};
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// checks
	`ASSERT_AR(a_ready_idle, clk, arst_n, s_tready |-> state_q == S_IDLE, "ready outside idle")
	`ASSERT_AR(a_rem_below_den, clk, arst_n, (state_q == S_DIV) |-> rem_q < den_q, "remainder not below divisor")
	`ASSERT_AR(a_div_runs, clk, arst_n, (state_q == S_DIV && step_q != 4'(DIV_STEPS - 1)) |=> state_q == S_DIV, "divider left early")
	`ASSERT_AR(a_done_posts, clk, arst_n, (state_q == S_DONE && out_free) |=> (!busy_q && cmpl_q && unread_q && m_tvalid_q), "completion not posted")

endmodule
